@@ rtl/bcuf_pkg.sv @@
package bcuf_pkg;

	// Fixed widths of the transaction fields and the register.
	localparam int VERTEX_W = 9;
	localparam int VCOUNT_W = 10;
	localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 10'd512;

	// Default vertex capacity of the store.
	localparam int VERTICES_DEF = 512;

	// Operations that the controller hands to the store.
	typedef enum logic [1:0] {
		OP_FIND,
		OP_LINK,
		OP_CLEAR
	} store_op_t;

	// Store sequencer states.
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_WALK,
		S_COMP,
		S_LINK
	} store_state_t;

	// Controller states.
	typedef enum logic [1:0] {
		T_IDLE,
		T_ISSUE,
		T_WAIT,
		T_FIN
	} ctrl_state_t;

	// Steps of one edge: two unions, each two finds and a link, then the check.
	typedef enum logic [2:0] {
		STEP_FIND_A,
		STEP_FIND_BO,
		STEP_LINK1,
		STEP_FIND_AO,
		STEP_FIND_B,
		STEP_LINK2,
		STEP_CHECK_A,
		STEP_CHECK_AO
	} step_t;

	// Request from the controller to the store.
	typedef struct packed {
		logic      start;
		store_op_t op;
	} bcuf_req_t;

	// Status from the store to the controller.
	typedef struct packed {
		logic done;
		logic ready;
	} bcuf_resp_t;

	// Step order of one edge.
	function automatic step_t next_step(input step_t s);
		step_t n;
		unique case (s)
			STEP_FIND_A:   n = STEP_FIND_BO;
			STEP_FIND_BO:  n = STEP_LINK1;
			STEP_LINK1:    n = STEP_FIND_AO;
			STEP_FIND_AO:  n = STEP_FIND_B;
			STEP_FIND_B:   n = STEP_LINK2;
			STEP_LINK2:    n = STEP_CHECK_A;
			STEP_CHECK_A:  n = STEP_CHECK_AO;
			STEP_CHECK_AO: n = STEP_FIND_A;
			default:       n = STEP_FIND_A;
		endcase
		return n;
	endfunction

endpackage

@@ rtl/bipartite_check_union_find_top.sv @@
// Bipartite check over a stream of edges, using a doubled-domain union-find
// store of 2*VERTICES entries (vertex v and its opposite v+VERTICES) held in
// one single-port-read memory. Each edge transaction runs six root finds and
// two links through one shared find sequencer; a find is a request, a walk to
// the root, then a compressing walk. After reset, and for every edge with
// first_edge set, a clearing pass marks every entry a root; no edge is
// accepted meanwhile, though vertex_count writes are. An edge with an
// endpoint at or above min(vertex_count, VERTICES) is flagged by bad_vertex
// and leaves the store untouched apart from any clear that first_edge asks
// for. The result register lets the next edge be accepted while the previous
// result waits.
module bipartite_check_union_find_top
	import bcuf_pkg::*;
#(
	parameter int VERTICES = VERTICES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [VCOUNT_W-1:0] cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [VERTEX_W-1:0] vertex_a,
	input  logic [VERTEX_W-1:0] vertex_b,
	input  logic                first_edge,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                edge_conflict,
	output logic                still_bipartite,
	output logic                bad_vertex
);

	localparam int SLOTS = 2 * VERTICES;
	localparam int IW    = $clog2(SLOTS);

	ctrl_state_t state_q, state_n;
	step_t       step_q;
	logic        clr_q;
	logic        bad_q;
	logic        seen_q;
	logic [VCOUNT_W-1:0] vcount_q;
	logic [VERTEX_W-1:0] a_q, b_q;
	logic [IW-1:0]       ra_q, rb_q;

	logic                out_valid_q;
	logic                edge_conflict_q, still_bipartite_q, bad_vertex_q;

	bcuf_req_t     req;
	bcuf_resp_t    resp;
	logic [IW-1:0] cmd_x, cmd_y;
	logic [IW-1:0] root;

	logic in_accept;
	logic bad_in;
	logic out_load;
	logic conflict;
	logic is_ra_step, is_rb_step;

	bcuf_store #(
		.VERTICES(VERTICES)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.x      (cmd_x),
		.y      (cmd_y),
		.resp   (resp),
		.root   (root)
	);

	// Range check against the smaller of the register and the capacity.
	assign bad_in = ({1'b0, vertex_a} >= vcount_q) || ({1'b0, vertex_b} >= vcount_q) ||
	                (32'(vertex_a) >= VERTICES) || (32'(vertex_b) >= VERTICES);

	assign in_stall  = !(state_q == T_IDLE && resp.ready);
	assign in_accept = in_valid && !in_stall;

	assign conflict = !bad_q && (ra_q == rb_q);
	assign out_load = (state_q == T_FIN) && (!out_valid_q || !out_stall);

	assign is_ra_step = (step_q == STEP_FIND_A) || (step_q == STEP_FIND_AO) ||
	                    (step_q == STEP_CHECK_A);
	assign is_rb_step = (step_q == STEP_FIND_BO) || (step_q == STEP_FIND_B) ||
	                    (step_q == STEP_CHECK_AO);

	// Operand of each step: an endpoint, its opposite, or the two roots.
	always_comb begin
		cmd_x = ra_q;
		cmd_y = rb_q;
		unique case (step_q)
			STEP_FIND_A, STEP_CHECK_A:   cmd_x = IW'(a_q);
			STEP_FIND_BO:                cmd_x = IW'(b_q) + IW'(VERTICES);
			STEP_FIND_AO, STEP_CHECK_AO: cmd_x = IW'(a_q) + IW'(VERTICES);
			STEP_FIND_B:                 cmd_x = IW'(b_q);
			STEP_LINK1, STEP_LINK2:      cmd_x = ra_q;
			default:                     cmd_x = ra_q;
		endcase
	end

	// Controller state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Next state and store requests.
	always_comb begin
		state_n   = state_q;
		req.start = 1'b0;
		req.op    = OP_FIND;
		unique case (state_q)
			T_IDLE: begin
				if (in_accept) begin
					if (first_edge || !bad_in) begin
						state_n = T_ISSUE;
					end else begin
						state_n = T_FIN;
					end
				end
			end
			T_ISSUE: begin
				req.start = 1'b1;
				if (clr_q) begin
					req.op = OP_CLEAR;
				end else if (step_q == STEP_LINK1 || step_q == STEP_LINK2) begin
					req.op = OP_LINK;
				end else begin
					req.op = OP_FIND;
				end
				state_n = T_WAIT;
			end
			T_WAIT: begin
				if (resp.done) begin
					if (clr_q) begin
						state_n = bad_q ? T_FIN : T_ISSUE;
					end else if (step_q == STEP_CHECK_AO) begin
						state_n = T_FIN;
					end else begin
						state_n = T_ISSUE;
					end
				end
			end
			T_FIN: begin
				if (out_load) begin
					state_n = T_IDLE;
				end
			end
			default: begin
				state_n = T_IDLE;
			end
		endcase
	end

	// Control registers: step, pending clear, sticky conflict and the register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= STEP_FIND_A;
			clr_q    <= 1'b0;
			bad_q    <= 1'b0;
			seen_q   <= 1'b0;
			vcount_q <= VCOUNT_RESET;
		end else begin
			if (cfg_we) begin
				vcount_q <= cfg_data;
			end
			if (in_accept) begin
				step_q <= STEP_FIND_A;
				clr_q  <= first_edge;
				bad_q  <= bad_in;
				if (first_edge) begin
					seen_q <= 1'b0;
				end
			end else if (state_q == T_WAIT && resp.done) begin
				if (clr_q) begin
					clr_q <= 1'b0;
				end else begin
					step_q <= next_step(step_q);
				end
			end else if (out_load && conflict) begin
				seen_q <= 1'b1;
			end
		end
	end

	// Edge endpoints and the roots found by each step.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			a_q <= vertex_a;
			b_q <= vertex_b;
		end
		if (state_q == T_WAIT && resp.done && !clr_q) begin
			if (is_ra_step) begin
				ra_q <= root;
			end
			if (is_rb_step) begin
				rb_q <= root;
			end
		end
	end

	// Result register; holds while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			edge_conflict_q   <= conflict;
			still_bipartite_q <= !(seen_q || conflict);
			bad_vertex_q      <= bad_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign edge_conflict   = edge_conflict_q;
	assign still_bipartite = still_bipartite_q;
	assign bad_vertex      = bad_vertex_q;

endmodule

@@ rtl/bcuf_store.sv @@
module bcuf_store
	import bcuf_pkg::*;
#(
	parameter int VERTICES = VERTICES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bcuf_req_t                           req,
	input  logic [$clog2(2*VERTICES)-1:0]       x,
	input  logic [$clog2(2*VERTICES)-1:0]       y,
	output bcuf_resp_t                          resp,
	output logic [$clog2(2*VERTICES)-1:0]       root
);

	localparam int SLOTS = 2 * VERTICES;
	localparam int IW    = $clog2(SLOTS);
	localparam int WW    = IW + 1;

	// Each word holds a root bit on top of the parent index.
	logic [WW-1:0] mem_q [SLOTS];
	logic [WW-1:0] rd_q;

	store_state_t state_q, state_n;
	logic [IW-1:0] cur_q, cur_n;
	logic [IW-1:0] x_q, x_n;
	logic [IW-1:0] y_q, y_n;
	logic [IW-1:0] root_q, root_n;
	logic [IW-1:0] clr_cnt_q, clr_cnt_n;

	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	logic [WW-1:0] mem_wdata;
	logic [IW-1:0] mem_raddr;

	logic          rd_root;
	logic [IW-1:0] rd_parent;

	assign rd_root   = rd_q[WW-1];
	assign rd_parent = rd_q[IW-1:0];

	// Memory with one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem_q[mem_raddr];
	end

	// Sequencer state and its working registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			state_q   <= state_n;
			clr_cnt_q <= clr_cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		cur_q  <= cur_n;
		x_q    <= x_n;
		y_q    <= y_n;
		root_q <= root_n;
	end

	// Clearing sweep, root walk, path compression and link.
	always_comb begin
		state_n    = state_q;
		cur_n      = cur_q;
		x_n        = x_q;
		y_n        = y_q;
		root_n     = root_q;
		clr_cnt_n  = clr_cnt_q;
		mem_we     = 1'b0;
		mem_waddr  = cur_q;
		mem_wdata  = {1'b0, root_q};
		mem_raddr  = cur_q;
		resp.done  = 1'b0;
		resp.ready = 1'b0;

		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_cnt_q;
				mem_wdata = {1'b1, {IW{1'b0}}};
				if (clr_cnt_q == IW'(SLOTS - 1)) begin
					clr_cnt_n = '0;
					resp.done = 1'b1;
					state_n   = S_IDLE;
				end else begin
					clr_cnt_n = clr_cnt_q + 1'b1;
				end
			end
			S_IDLE: begin
				resp.ready = 1'b1;
				if (req.start) begin
					unique case (req.op)
						OP_FIND: begin
							mem_raddr = x;
							cur_n     = x;
							x_n       = x;
							state_n   = S_WALK;
						end
						OP_LINK: begin
							x_n     = x;
							y_n     = y;
							state_n = S_LINK;
						end
						OP_CLEAR: begin
							clr_cnt_n = '0;
							state_n   = S_CLEAR;
						end
						default: begin
							state_n = S_IDLE;
						end
					endcase
				end
			end
			S_WALK: begin
				// Read data belongs to cur_q; follow links until a root shows.
				if (rd_root) begin
					root_n    = cur_q;
					mem_raddr = x_q;
					cur_n     = x_q;
					state_n   = S_COMP;
				end else begin
					mem_raddr = rd_parent;
					cur_n     = rd_parent;
				end
			end
			S_COMP: begin
				// Second walk from the start entry, pointing each one at the root.
				if (cur_q == root_q || rd_root) begin
					resp.done = 1'b1;
					state_n   = S_IDLE;
				end else begin
					mem_we    = 1'b1;
					mem_waddr = cur_q;
					mem_wdata = {1'b0, root_q};
					mem_raddr = rd_parent;
					cur_n     = rd_parent;
				end
			end
			S_LINK: begin
				// The larger root goes under the smaller one.
				if (x_q != y_q) begin
					mem_we = 1'b1;
					if (x_q < y_q) begin
						mem_waddr = y_q;
						mem_wdata = {1'b0, x_q};
					end else begin
						mem_waddr = x_q;
						mem_wdata = {1'b0, y_q};
					end
				end
				resp.done = 1'b1;
				state_n   = S_IDLE;
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	assign root = root_q;

endmodule

@@ sim/bipartite_check_union_find_top_test.sv @@
`timescale 1ns / 1ps

module bipartite_check_union_find_top_test;
	import bcuf_pkg::*;

	localparam int NV = VERTICES_DEF;
	localparam int SLOTS = 2 * NV;
	// Cycles to let pass once the last result is in, before a register write or the end.
	localparam int SETTLE_CYCLES = 64;
	// Far above a slow correct run: every edge with a clear pass and long stalls.
	localparam int LIMIT_CYCLES = 20000000;

	// One result transaction.
	typedef struct packed {
		logic conflict;
		logic bipartite;
		logic bad;
	} edge_result_t;

	// One row of the directed table; typed rows carry their expected result.
	typedef struct packed {
		logic [VCOUNT_W-1:0] vc;
		logic [VERTEX_W-1:0] a;
		logic [VERTEX_W-1:0] b;
		logic                first;
		logic                typed;
		edge_result_t        res;
	} edge_row_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [VCOUNT_W-1:0] cfg_data;
	logic                in_valid;
	logic                in_stall;
	logic [VERTEX_W-1:0] vertex_a;
	logic [VERTEX_W-1:0] vertex_b;
	logic                first_edge;
	logic                out_valid;
	logic                out_stall;
	logic                edge_conflict;
	logic                still_bipartite;
	logic                bad_vertex;

	// Shadow union-find store and register.
	int unsigned         uf_link [SLOTS];
	bit                  uf_root [SLOTS];
	bit                  odd_cycle_seen;
	logic [VCOUNT_W-1:0] vcount_shadow;

	edge_result_t pending_results[$];
	int           fail_count = 0;
	int           snd_pct;
	int           rcv_pct;
	longint       cycle_count = 0;

	bipartite_check_union_find_top #(
		.VERTICES(NV)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.vertex_a(vertex_a),
		.vertex_b(vertex_b),
		.first_edge(first_edge),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.edge_conflict(edge_conflict),
		.still_bipartite(still_bipartite),
		.bad_vertex(bad_vertex)
	);

	// Clock generation.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("bipartite_check_union_find_top_test: errors");
			$finish;
		end
	end

	// Marks every entry a root and forgets earlier conflicts.
	function automatic void wipe_store();
		foreach (uf_root[i])
			uf_root[i] = 1'b1;
		odd_cycle_seen = 1'b0;
	endfunction

	// Root lookup with path compression; roots are always the smallest member.
	function automatic int unsigned root_of(input int unsigned x);
		int unsigned r;
		int unsigned c;
		int unsigned nx;
		r = x;
		while (!uf_root[r])
			r = uf_link[r];
		c = x;
		while (c != r && !uf_root[c]) begin
			nx = uf_link[c];
			uf_link[c] = r;
			c = nx;
		end
		return r;
	endfunction

	// Joins two sets, the larger root going under the smaller one.
	function automatic void join_sets(input int unsigned x, input int unsigned y);
		int unsigned rx;
		int unsigned ry;
		rx = root_of(x);
		ry = root_of(y);
		if (rx != ry) begin
			if (rx < ry) begin
				uf_link[ry] = rx;
				uf_root[ry] = 1'b0;
			end else begin
				uf_link[rx] = ry;
				uf_root[rx] = 1'b0;
			end
		end
	endfunction

	// Expected outcome of one edge, updating the shadow store.
	function automatic edge_result_t predict_edge(input logic [VERTEX_W-1:0] a,
			input logic [VERTEX_W-1:0] b, input logic first);
		edge_result_t r;
		int unsigned lim;
		lim = (vcount_shadow > NV) ? NV : vcount_shadow;
		r = '0;
		if (first)
			wipe_store();
		if (a >= lim || b >= lim) begin
			r.bad = 1'b1;
		end else begin
			join_sets(a, b + NV);
			join_sets(a + NV, b);
			r.conflict = (root_of(a) == root_of(a + NV)) || (root_of(b) == root_of(b + NV));
			if (r.conflict)
				odd_cycle_seen = 1'b1;
		end
		r.bipartite = !odd_cycle_seen;
		return r;
	endfunction

	function automatic edge_row_t mk_row(input int unsigned vc, input int unsigned a,
			input int unsigned b, input bit first, input bit typed,
			input bit c, input bit bip, input bit bad);
		edge_row_t r;
		r.vc = VCOUNT_W'(vc);
		r.a = VERTEX_W'(a);
		r.b = VERTEX_W'(b);
		r.first = first;
		r.typed = typed;
		r.res = {c, bip, bad};
		return r;
	endfunction

	// Drives one edge transaction and records its expected result once accepted.
	task automatic send_edge(input logic [VERTEX_W-1:0] a, input logic [VERTEX_W-1:0] b,
			input logic first, input bit typed, input edge_result_t typed_res);
		edge_result_t want;
		while ($urandom_range(0, 99) < snd_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		vertex_a <= a;
		vertex_b <= b;
		first_edge <= first;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		want = predict_edge(a, b, first);
		pending_results.push_back(typed ? typed_res : want);
	endtask

	// Writes vertex_count once the block has drained.
	task automatic write_vcount(input logic [VCOUNT_W-1:0] v);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		vcount_shadow = v;
	endtask

	// Result checker and receiver stalls.
	always @(posedge clk) begin : check_results
		edge_result_t got;
		edge_result_t want;
		if (out_valid && !out_stall) begin
			got = {edge_conflict, still_bipartite, bad_vertex};
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result transaction %b", $time, got);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (got.conflict !== want.conflict) begin
					$display("%0t: edge_conflict expected %b got %b", $time,
						want.conflict, got.conflict);
					fail_count++;
				end
				if (got.bipartite !== want.bipartite) begin
					$display("%0t: still_bipartite expected %b got %b", $time,
						want.bipartite, got.bipartite);
					fail_count++;
				end
				if (got.bad !== want.bad) begin
					$display("%0t: bad_vertex expected %b got %b", $time,
						want.bad, got.bad);
					fail_count++;
				end
			end
		end
		out_stall <= ($urandom_range(0, 99) < rcv_pct);
	end

	// Stimulus.
	initial begin : stimulus
		edge_row_t           dir_tbl[$];
		int unsigned         seg_vc[11];
		int unsigned         seg_quota[11];
		logic [VERTEX_W-1:0] grp0[0:127];
		logic [VERTEX_W-1:0] grp1[0:127];
		logic [VERTEX_W-1:0] a;
		logic [VERTEX_W-1:0] b;
		logic [VERTEX_W-1:0] t;
		int unsigned         lim;
		int unsigned         k;
		int unsigned         n0;
		int unsigned         n1;
		int unsigned         len;
		int unsigned         odd_pct;
		int unsigned         cnt;

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		vertex_a <= '0;
		vertex_b <= '0;
		first_edge <= 1'b0;
		snd_pct = 7;
		rcv_pct = 61;
		wipe_store();
		vcount_shadow = VCOUNT_RESET;

		// Directed edges: triangles, self loops, extremes, rejected endpoints, clears.
		dir_tbl.push_back(mk_row(512, 0, 1, 1, 1, 0, 1, 0));
		dir_tbl.push_back(mk_row(512, 1, 2, 0, 0, 0, 0, 0));
		dir_tbl.push_back(mk_row(512, 2, 0, 0, 1, 1, 0, 0));
		dir_tbl.push_back(mk_row(512, 3, 4, 0, 0, 0, 0, 0));
		dir_tbl.push_back(mk_row(512, 511, 511, 1, 1, 1, 0, 0));
		dir_tbl.push_back(mk_row(512, 0, 0, 1, 1, 1, 0, 0));
		dir_tbl.push_back(mk_row(512, 5, 6, 1, 1, 0, 1, 0));
		dir_tbl.push_back(mk_row(512, 511, 0, 0, 0, 0, 0, 0));
		dir_tbl.push_back(mk_row(512, 6, 511, 0, 0, 0, 0, 0));
		dir_tbl.push_back(mk_row(512, 5, 511, 0, 0, 0, 0, 0));
		dir_tbl.push_back(mk_row(512, 341, 170, 1, 1, 0, 1, 0));
		dir_tbl.push_back(mk_row(512, 170, 341, 0, 0, 0, 0, 0));
		dir_tbl.push_back(mk_row(1, 0, 0, 1, 1, 1, 0, 0));
		dir_tbl.push_back(mk_row(1, 0, 1, 0, 1, 0, 0, 1));
		dir_tbl.push_back(mk_row(1, 1, 0, 1, 1, 0, 1, 1));
		dir_tbl.push_back(mk_row(1, 0, 0, 0, 1, 1, 0, 0));
		dir_tbl.push_back(mk_row(0, 0, 0, 0, 1, 0, 0, 1));
		dir_tbl.push_back(mk_row(0, 0, 0, 1, 1, 0, 1, 1));
		dir_tbl.push_back(mk_row(1023, 511, 510, 0, 1, 0, 1, 0));
		dir_tbl.push_back(mk_row(1023, 510, 511, 0, 0, 0, 0, 0));
		dir_tbl.push_back(mk_row(513, 511, 0, 0, 0, 0, 0, 0));
		dir_tbl.push_back(mk_row(2, 1, 2, 0, 0, 0, 0, 0));
		dir_tbl.push_back(mk_row(2, 2, 1, 0, 0, 0, 0, 0));
		dir_tbl.push_back(mk_row(2, 1, 1, 0, 0, 0, 0, 0));

		// Random phases: register setting and number of in-range edges per phase (any edges where the register is 0).
		seg_vc = '{512, 16, 1, 300, 64, 0, 1023, 8, 511, 2, 512};
		seg_quota = '{180, 180, 60, 180, 180, 20, 180, 180, 180, 100, 180};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_tbl[i]) begin
			if (dir_tbl[i].vc != vcount_shadow)
				write_vcount(dir_tbl[i].vc);
			send_edge(dir_tbl[i].a, dir_tbl[i].b, dir_tbl[i].first, dir_tbl[i].typed,
				dir_tbl[i].res);
		end

		for (int s = 0; s < 11; s++) begin
			write_vcount(VCOUNT_W'(seg_vc[s]));
			if (s < 4) begin
				snd_pct = 7;
				rcv_pct = 61;
			end else if (s < 8) begin
				snd_pct = 61;
				rcv_pct = 7;
			end else begin
				snd_pct = 0;
				rcv_pct = 0;
			end
			lim = (vcount_shadow > NV) ? NV : vcount_shadow;
			cnt = 0;
			while (cnt < seg_quota[s]) begin
				if ($urandom_range(0, 99) < 85) begin
					// A graph on a two-sided vertex pool, mostly bipartite, some odd edges.
					k = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 200)
						: $urandom_range(2, 16);
					n0 = k / 2;
					n1 = k - n0;
					for (int i = 0; i < n0; i++)
						grp0[i] = VERTEX_W'((lim == 0) ? $urandom_range(0, 511)
							: $urandom_range(0, lim - 1));
					for (int i = 0; i < n1; i++)
						grp1[i] = VERTEX_W'((lim == 0) ? $urandom_range(0, 511)
							: $urandom_range(0, lim - 1));
					len = $urandom_range(1, 48);
					odd_pct = $urandom_range(0, 12);
					for (int j = 0; j < len && cnt < seg_quota[s]; j++) begin
						a = grp0[$urandom_range(0, n0 - 1)];
						if ($urandom_range(0, 99) < odd_pct)
							b = grp0[$urandom_range(0, n0 - 1)];
						else
							b = grp1[$urandom_range(0, n1 - 1)];
						if ($urandom_range(0, 1)) begin
							t = a;
							a = b;
							b = t;
						end
						send_edge(a, b, j == 0, 1'b0, '0);
						if (lim == 0 || (a < lim && b < lim))
							cnt++;
					end
				end else begin
					// Noise: any endpoints, occasional clear.
					a = VERTEX_W'($urandom_range(0, 511));
					b = VERTEX_W'($urandom_range(0, 511));
					send_edge(a, b, $urandom_range(0, 9) == 0, 1'b0, '0);
					if (lim == 0 || (a < lim && b < lim))
						cnt++;
				end
			end
		end

		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("bipartite_check_union_find_top_test: clean");
		else
			$display("bipartite_check_union_find_top_test: errors");
		$finish;
	end

endmodule

@@ bipartite_check_union_find_top.f @@
rtl/bcuf_pkg.sv
rtl/bcuf_store.sv
rtl/bipartite_check_union_find_top.sv
sim/bipartite_check_union_find_top_test.sv
